// ----- src/kuz_pkg.sv -----
// Shared types, tables and GF(2^8) helpers for the Kuznyechik core.
`default_nettype none
package kuz_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [0:255][7:0] sbox_t;
  typedef logic [15:0][15:0][7:0] lmat_t;
  typedef logic [9:0][127:0] rkeys_t;

  localparam int NumRoundKeys = 10;
  localparam int KeyWordWidth = 64;
  localparam int CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_3 = 3'd3;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  localparam sbox_t PI = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  // coefficient of byte i in the linear function l, byte 0 at index 0
  localparam logic [15:0][7:0] LIN_COEF = {
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ 9'h1C3;
    end
    return acc;
  endfunction

  function automatic logic [7:0] lin_fn(input blk_t a);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 16; i++) s = s ^ gf_mul(a[8*i +: 8], LIN_COEF[i]);
    return s;
  endfunction

  // 16-step register form of L and its inverse; elaboration only
  function automatic blk_t lin_slow(input blk_t a, input logic inv);
    blk_t t;
    logic [7:0] v;
    t = a;
    for (int r = 0; r < 16; r++) begin
      if (!inv) begin
        v = lin_fn(t);
        t = {v, t[127:8]};
      end else begin
        t = {t[119:0], t[127:120]};
        t[7:0] = lin_fn(t);
      end
    end
    return t;
  endfunction

  function automatic lmat_t build_lmat(input logic inv);
    lmat_t m;
    blk_t e;
    for (int i = 0; i < 16; i++) begin
      e = '0;
      e[8*i +: 8] = 8'h01;
      e = lin_slow(e, inv);
      for (int j = 0; j < 16; j++) m[j][i] = e[8*j +: 8];
    end
    return m;
  endfunction

  function automatic sbox_t build_inv_sbox();
    sbox_t t;
    t = '0;
    for (int i = 0; i < 256; i++) t[PI[i]] = 8'(i);
    return t;
  endfunction

  localparam lmat_t LMAT = build_lmat(1'b0);
  localparam lmat_t LMAT_INV = build_lmat(1'b1);
  localparam sbox_t PI_INV = build_inv_sbox();

  function automatic blk_t s_fwd(input blk_t a);
    blk_t o;
    for (int i = 0; i < 16; i++) o[8*i +: 8] = PI[a[8*i +: 8]];
    return o;
  endfunction

  function automatic blk_t s_inv(input blk_t a);
    blk_t o;
    for (int i = 0; i < 16; i++) o[8*i +: 8] = PI_INV[a[8*i +: 8]];
    return o;
  endfunction

  function automatic blk_t l_apply(input blk_t a, input lmat_t m);
    blk_t o;
    logic [7:0] acc;
    for (int j = 0; j < 16; j++) begin
      acc = 8'h00;
      for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(a[8*i +: 8], m[j][i]);
      o[8*j +: 8] = acc;
    end
    return o;
  endfunction

  // C(c) = L(c in byte 0)
  function automatic blk_t round_const(input logic [7:0] c);
    blk_t o;
    for (int j = 0; j < 16; j++) o[8*j +: 8] = gf_mul(c, LMAT[j][0]);
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- src/kuz_key_sched.sv -----
// Key word registers and the iterative round key expansion.
`default_nettype none
module kuz_key_sched
  import kuz_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [KeyWordWidth-1:0]  cfg_data,
  output logic                          busy,
  output rkeys_t                        round_keys
);

  logic [3:0][KeyWordWidth-1:0] key_words;
  logic [5:0] cnt;
  blk_t left, right;
  blk_t left_next, right_next;
  blk_t f_in, f_out;

  always_comb begin
    f_in = cnt[0] ? left : right;
    f_out = l_apply(s_fwd(f_in ^ round_const({2'b00, cnt})), LMAT);
    left_next = left;
    right_next = right;
    if (cnt[0]) right_next = right ^ f_out;
    else left_next = left ^ f_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_words <= '0;
      busy <= 1'b1;
      cnt <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD_0: begin key_words[0] <= cfg_data; busy <= 1'b1; cnt <= 6'd0; end
        REG_KEY_WORD_1: begin key_words[1] <= cfg_data; busy <= 1'b1; cnt <= 6'd0; end
        REG_KEY_WORD_2: begin key_words[2] <= cfg_data; busy <= 1'b1; cnt <= 6'd0; end
        REG_KEY_WORD_3: begin key_words[3] <= cfg_data; busy <= 1'b1; cnt <= 6'd0; end
        default: ;
      endcase
    end else if (busy) begin
      if (cnt == 6'd0) begin
        left <= {key_words[1], key_words[0]};
        right <= {key_words[3], key_words[2]};
        round_keys[0] <= {key_words[1], key_words[0]};
        round_keys[1] <= {key_words[3], key_words[2]};
        cnt <= 6'd1;
      end else begin
        left <= left_next;
        right <= right_next;
        if (cnt[2:0] == 3'd0) begin
          round_keys[{cnt[5:3], 1'b0}] <= left_next;
          round_keys[{cnt[5:3], 1'b1}] <= right_next;
        end
        if (cnt == 6'd32) busy <= 1'b0;
        else cnt <= cnt + 6'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/kuz_round.sv -----
// One registered cipher round: LSX forward or inverse LSX, chosen per block.
`default_nettype none
module kuz_round
  import kuz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic prev_valid,
  input  wire logic prev_type,
  input  wire blk_t prev_data,
  input  wire blk_t key_enc,
  input  wire blk_t key_dec,
  output logic      valid,
  output logic      req,
  output blk_t      data
);

  blk_t data_next;

  always_comb begin
    if (prev_type == REQ_DECRYPT) data_next = s_inv(l_apply(prev_data, LMAT_INV)) ^ key_dec;
    else data_next = l_apply(s_fwd(prev_data), LMAT) ^ key_enc;
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (en) valid <= prev_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req <= prev_type;
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/kuznyechik_block_cipher_core.sv -----
// Top level of the Kuznyechik 128-bit block cipher engine (ECB).
`default_nettype none
// Encrypts or decrypts one 128-bit block per beat, req_type choosing the direction
// (0 encrypt, 1 decrypt); byte 0 of a block sits in bits 7:0 of the low word. The
// datapath is a ten-stage pipeline: a key whitening stage and nine round stages,
// each one register deep, and a new block can enter every cycle while the result
// side is not stalled and the key expander is idle. A stall on the result side
// holds the whole pipeline in place. The round keys come from an iterative expander
// that runs one Feistel round per cycle: after reset and after every write to a key
// word it rebuilds the ten round keys, and in_ready stays low meanwhile.
// Key words 0..3 sit at configuration indexes 0..3; writes to other indexes are
// dropped. Write keys only while no block is in flight.
module kuznyechik_block_cipher_core
  import kuz_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [KeyWordWidth-1:0]  cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     req_type,
  input  wire logic [63:0]              block_lo,
  input  wire logic [63:0]              block_hi,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [63:0]                   result_lo,
  output logic [63:0]                   result_hi
);

  logic   sched_busy;
  rkeys_t round_keys;
  logic   en;

  logic [NumRoundKeys-1:0]       st_valid;
  logic [NumRoundKeys-1:0]       st_type;
  logic [NumRoundKeys-1:0][127:0] st_data;

  kuz_key_sched u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (sched_busy),
    .round_keys (round_keys)
  );

  // advance everything unless the result beat is stalled
  assign en = !st_valid[NumRoundKeys-1] || out_ready;
  assign in_ready = en && !sched_busy;

  // whitening stage: X[K1] for encryption, X[K10] for decryption
  always_ff @(posedge clk) begin
    if (rst) st_valid[0] <= 1'b0;
    else if (en) st_valid[0] <= in_valid && !sched_busy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_type[0] <= req_type;
      st_data[0] <= {block_hi, block_lo} ^
                    ((req_type == REQ_DECRYPT) ? round_keys[NumRoundKeys-1] : round_keys[0]);
    end
  end

  for (genvar k = 1; k < NumRoundKeys; k++) begin : g_round
    kuz_round u_round (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (st_valid[k-1]),
      .prev_type  (st_type[k-1]),
      .prev_data  (st_data[k-1]),
      .key_enc    (round_keys[k]),
      .key_dec    (round_keys[NumRoundKeys-1-k]),
      .valid      (st_valid[k]),
      .req        (st_type[k]),
      .data       (st_data[k])
    );
  end

  assign out_valid = st_valid[NumRoundKeys-1];
  assign result_lo = st_data[NumRoundKeys-1][63:0];
  assign result_hi = st_data[NumRoundKeys-1][127:64];

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the Kuznyechik block cipher core.
`timescale 1ns / 1ps

module tb_top;
  import kuz_pkg::*;

  // Substitution table pi, byte value x maps to entry x
  localparam logic [0:255][7:0] SBOX_TAB = {
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  // Coefficients of the linear form l, byte 0 first
  localparam logic [0:15][7:0] L_COEF = {
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_RANDOM = 800;
  localparam int NUM_KEY_PHASES = 6;

  // Holds the key schedule, predicts each block and checks results in order
  class cipher_scoreboard;
    logic [63:0]  key_word [4];
    logic [127:0] round_key [10];
    logic [7:0]   inv_sbox [256];
    logic [127:0] expected_q [$];
    int           errors;

    function new();
      for (int i = 0; i < 256; i++) inv_sbox[SBOX_TAB[i]] = 8'(i);
      for (int i = 0; i < 4; i++) key_word[i] = '0;
      errors = 0;
      expand_keys();
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x = {1'b0, a};
      acc = '0;
      for (int k = 0; k < 8; k++) begin
        if (b[k]) acc ^= x[7:0];
        x = {x[7:0], 1'b0};
        if (x[8]) x ^= 9'h1C3;
      end
      return acc;
    endfunction

    function logic [7:0] lin_sum(logic [127:0] a);
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < 16; i++) s ^= gmul(a[8*i +: 8], L_COEF[i]);
      return s;
    endfunction

    function logic [127:0] mix_fwd(logic [127:0] a);
      for (int r = 0; r < 16; r++) a = {lin_sum(a), a[127:8]};
      return a;
    endfunction

    function logic [127:0] mix_inv(logic [127:0] a);
      for (int r = 0; r < 16; r++) begin
        a = {a[119:0], a[127:120]};
        a[7:0] = lin_sum(a);
      end
      return a;
    endfunction

    function logic [127:0] sub_fwd(logic [127:0] a);
      for (int i = 0; i < 16; i++) a[8*i +: 8] = SBOX_TAB[a[8*i +: 8]];
      return a;
    endfunction

    function logic [127:0] sub_inv(logic [127:0] a);
      for (int i = 0; i < 16; i++) a[8*i +: 8] = inv_sbox[a[8*i +: 8]];
      return a;
    endfunction

    // Ten round keys from the four key words by 32 Feistel rounds
    function void expand_keys();
      logic [127:0] left, right, cst;
      int c;
      left = {key_word[1], key_word[0]};
      right = {key_word[3], key_word[2]};
      round_key[0] = left;
      round_key[1] = right;
      for (int p = 1; p < 5; p++) begin
        for (int j = 0; j < 8; j++) begin
          c = 8 * (p - 1) + j + 1;
          cst = mix_fwd({120'd0, 8'(c)});
          if (j % 2 == 0) right ^= mix_fwd(sub_fwd(left ^ cst));
          else left ^= mix_fwd(sub_fwd(right ^ cst));
        end
        round_key[2*p] = left;
        round_key[2*p+1] = right;
      end
    endfunction

    function void set_key(logic [CfgIndexWidth-1:0] idx, logic [63:0] val);
      if (idx > REG_KEY_WORD_3) return;
      key_word[idx[1:0]] = val;
      expand_keys();
    endfunction

    function void note_block(logic req, logic [63:0] lo, logic [63:0] hi);
      logic [127:0] b;
      b = {hi, lo};
      if (req == REQ_ENCRYPT) begin
        b ^= round_key[0];
        for (int r = 1; r < 10; r++) b = mix_fwd(sub_fwd(b)) ^ round_key[r];
      end else begin
        b ^= round_key[9];
        for (int r = 8; r >= 0; r--) b = sub_inv(mix_inv(b)) ^ round_key[r];
      end
      expected_q.push_back(b);
    endfunction

    function void check_result(logic [63:0] lo, logic [63:0] hi);
      logic [127:0] e;
      if (expected_q.size() == 0) begin
        $error("result_lo/result_hi: unexpected result %h %h", lo, hi);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (lo !== e[63:0]) begin
        $error("result_lo: expected %h, actual %h", e[63:0], lo);
        errors++;
      end
      if (hi !== e[127:64]) begin
        $error("result_hi: expected %h, actual %h", e[127:64], hi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [KeyWordWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_ENCRYPT;
  logic [63:0] block_lo = '0;
  logic [63:0] block_hi = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] result_lo;
  logic [63:0] result_hi;

  // When set, neither side idles: back-to-back stretches
  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  cipher_scoreboard cipher_sb;

  always #5 clk = ~clk;

  kuznyechik_block_cipher_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .block_lo (block_lo),
    .block_hi (block_hi),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_lo(result_lo),
    .result_hi(result_hi)
  );

  // Gap length: mostly none or short, now and then long
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one block; hold valid for the next one, or drop it and idle a while
  task automatic send_block(logic req, logic [63:0] lo, logic [63:0] hi, bit last);
    int gap;
    in_valid <= 1'b1;
    req_type <= req;
    block_lo <= lo;
    block_hi <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_sb.note_block(req, lo, hi);
    gap = pick_gap();
    if (last || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap > 0 ? gap : 1) @(posedge clk);
    end
  endtask

  // Drain the pipeline before the key may change
  task automatic wait_drained();
    while (cipher_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write, then let the key expander finish
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cipher_sb.set_key(idx, val);
    cfg_we <= 1'b0;
    repeat (40) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    wait_drained();
    write_reg(REG_KEY_WORD_0, k0);
    write_reg(REG_KEY_WORD_1, k1);
    write_reg(REG_KEY_WORD_2, k2);
    write_reg(REG_KEY_WORD_3, k3);
  endtask

  function logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Result side: random back-pressure with occasional long stalls
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) cipher_sb.check_result(result_lo, result_hi);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Watchdog: abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    cipher_sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset key, extreme blocks in both directions
    send_block(REQ_ENCRYPT, '0, '0, 1'b0);
    send_block(REQ_DECRYPT, '0, '0, 1'b0);
    send_block(REQ_ENCRYPT, '1, '1, 1'b0);
    send_block(REQ_DECRYPT, '1, '1, 1'b0);
    send_block(REQ_ENCRYPT, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b1);

    // Published test key and block
    load_key(64'h0011223344556677, 64'h8899AABBCCDDEEFF,
             64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    send_block(REQ_ENCRYPT, 64'hFFEEDDCCBBAA9988, 64'h1122334455667700, 1'b0);
    send_block(REQ_DECRYPT, 64'hFFEEDDCCBBAA9988, 64'h1122334455667700, 1'b0);
    send_block(REQ_DECRYPT, 64'h90A8E7E46BCE9093, 64'h7F679D90BEBC2430, 1'b0);
    send_block(REQ_ENCRYPT, '0, '1, 1'b1);

    // Writes to unused indexes must leave the key alone
    wait_drained();
    write_reg(3'd4, '1);
    write_reg(3'd7, 64'h0123456789ABCDEF);
    send_block(REQ_ENCRYPT, '1, '0, 1'b0);
    send_block(REQ_DECRYPT, '1, '0, 1'b1);

    // All-ones key
    load_key('1, '1, '1, '1);
    send_block(REQ_ENCRYPT, '0, '0, 1'b0);
    send_block(REQ_DECRYPT, '1, '1, 1'b0);
    send_block(REQ_ENCRYPT, 64'h8000000000000001, 64'h8000000000000001, 1'b1);

    // Random phases, each under its own key; the drain at each key change
    // also makes the sender wait until every result is back
    for (int ph = 0; ph < NUM_KEY_PHASES; ph++) begin
      load_key(rand_word(), rand_word(), rand_word(), rand_word());
      calm = (ph == 2);
      for (int n = 0; n < NUM_RANDOM / NUM_KEY_PHASES; n++)
        send_block(1'($urandom), rand_word(), rand_word(),
                   n == NUM_RANDOM / NUM_KEY_PHASES - 1);
    end
    calm = 1'b0;

    // Back to the all-zero key at the end
    load_key('0, '0, '0, '0);
    send_block(REQ_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_block(REQ_DECRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);

    wait_drained();
    if (cipher_sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
